[sv/wavenumber_dip_taper_filter_defines.svh]
// Assertion macros used by the checker file
`ifndef WAVENUMBER_DIP_TAPER_FILTER_DEFINES_SVH
`define WAVENUMBER_DIP_TAPER_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define WDTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define WDTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wdtf_pkg.sv]
package wdtf_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int WN_W           = 20;
    localparam int LEN_W          = 13;
    localparam int SINE_W         = 17;
    localparam int FRAC_W         = 16;
    localparam int BIN_W          = 12;
    localparam int RECIP_W        = 18;
    localparam int WEIGHT_W       = 17;
    localparam int KPOS_W         = WN_W + SINE_W;
    localparam int TABLE_DEPTH    = 1024;
    localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int TDATA_IN_W     = 72;
    localparam int TDATA_OUT_W    = 48;
    localparam int CFG_DATA_W     = 17;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(4096);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_LENGTH,
        CFG_ANGLE_SINE,
        CFG_OPEN_TO_NYQUIST,
        CFG_TAPER_FRACTION
    } cfg_index_t;

    typedef enum logic [1:0] {
        WCLS_ZERO,
        WCLS_ONE,
        WCLS_TAPER
    } weight_class_t;

    typedef struct packed {
        logic [LEN_W-1:0]         row_length;
        logic [SINE_W-1:0]        angle_sine;
        logic                     open_to_nyquist;
        logic signed [FRAC_W-1:0] taper_fraction;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        weight_class_t              cls;
        logic [BIN_W-1:0]           offset;
        logic [RECIP_W-1:0]         recip;
        logic                       last;
    } work_item_t;

    typedef logic [WEIGHT_W-1:0] cos_table_t [TABLE_DEPTH];

    // Raised cosine weights, cos^2 in Q16, from a Q30 Taylor series
    function automatic cos_table_t build_cos_table();
        cos_table_t  tbl;
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] t;
        longint      sum;
        logic [63:0] c;
        logic [63:0] w;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            y   = (64'd1686629713 * 64'(j)) / TABLE_DEPTH;
            y2  = (y * y) >> 30;
            t   = 64'd1 << 30;
            sum = 64'sd1 << 30;
            for (int n = 1; n <= 12; n++) begin
                t = ((t * y2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    sum = sum - longint'(t);
                else
                    sum = sum + longint'(t);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 << 30))
                sum = 64'sd1 << 30;
            c = 64'(sum);
            w = (c * c + (64'd1 << 43)) >> 44;
            if (w > 64'd65536)
                w = 64'd65536;
            tbl[j] = w[WEIGHT_W-1:0];
        end
        return tbl;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

[sv/wdtf_queue.sv]
module wdtf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wdtf_pkg::work_item_t push_item,
    output logic                full,
    input  logic                pop,
    output wdtf_pkg::work_item_t pop_item,
    output logic                not_empty
);
    import wdtf_pkg::*;

    work_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[sv/wdtf_front.sv]
module wdtf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wdtf_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wdtf_pkg::TDATA_IN_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    output logic                                push,
    output wdtf_pkg::work_item_t                push_item,
    input  logic                                full
);
    import wdtf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KPOS,
        ST_NTAP,
        ST_EDGE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [BIN_W-1:0]            bin_reg;
    logic [BIN_W-1:0]            start_reg;
    logic [BIN_W-1:0]            cut_reg;
    logic [RECIP_W-1:0]          recip_reg;
    logic signed [SAMPLE_W-1:0]  hold_re_reg;
    logic signed [SAMPLE_W-1:0]  hold_im_reg;
    logic [WN_W-1:0]             hold_wn_reg;
    logic [KPOS_W-1:0]           kpos_reg;
    logic [17:0]                 ntap_reg;
    logic [17:0]                 tap_q_reg;
    logic [BIN_W-1:0]            clip_reg;
    logic                        hi_reg;
    logic [BIN_W-1:0]            div_reg;
    logic [BIN_W:0]              rem_reg;
    logic [RECIP_W-1:0]          quo_reg;
    logic [4:0]                  dcnt_reg;

    logic [LEN_W-1:0]            len_raw, len_eff;
    logic [BIN_W-1:0]            nyq;
    logic signed [SAMPLE_W-1:0]  in_re, in_im;
    logic [WN_W-1:0]             in_wn;
    logic                        accept;
    logic [LEN_W-1:0]            bin_ext, m_full;
    logic [BIN_W-1:0]            m;
    weight_class_t               cls;
    logic                        last;
    logic [BIN_W-1:0]            bin_next;

    logic [FRAC_W-1:0]           afrac;
    logic                        frac_pos, frac_oor;
    logic [53:0]                 ntap_prod;
    logic [14:0]                 tap_x;
    logic [29:0]                 tap_prod;
    logic [15:0]                 clip_x;
    logic [31:0]                 clip_prod;
    logic [41:0]                 kpos20, nyq17q;
    logic [KPOS_W-1:0]           nyq_q;
    logic [42:0]                 kpos_sum;
    logic [12:0]                 kint;
    logic [18:0]                 ik1, ik2, nt;
    logic [BIN_W:0]              trial;

    assign in_re  = s_tdata[SAMPLE_W-1:0];
    assign in_im  = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign in_wn  = s_tdata[2*SAMPLE_W+WN_W-1:2*SAMPLE_W];
    assign s_tready = (state_reg == ST_IDLE) && !full;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        len_raw = {cfg.row_length[LEN_W-1:1], 1'b0};
        if (len_raw < MIN_LEN)
            len_eff = MIN_LEN;
        else if (len_raw > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = len_raw;
        nyq = len_eff[LEN_W-1:1];
    end

    // Classify the current bin by its index mirrored about Nyquist
    always_comb
    begin
        bin_ext = {1'b0, bin_reg};
        m_full  = '0;
        cls     = WCLS_ZERO;
        last    = 1'b1;
        if (bin_ext < len_eff)
        begin
            m_full = (bin_ext <= {1'b0, nyq}) ? bin_ext : len_eff - bin_ext;
            last   = (bin_ext == len_eff - 1'b1);
            if (m_full[BIN_W-1:0] < start_reg)
                cls = WCLS_ONE;
            else if (m_full[BIN_W-1:0] < cut_reg)
                cls = WCLS_TAPER;
            else
                cls = WCLS_ZERO;
        end
        m        = m_full[BIN_W-1:0];
        bin_next = last ? '0 : bin_reg + 1'b1;
    end

    always_comb
    begin
        push = (accept && !s_tuser) || ((state_reg == ST_EMIT) && !full);
        push_item.re     = (state_reg == ST_EMIT) ? hold_re_reg : in_re;
        push_item.im     = (state_reg == ST_EMIT) ? hold_im_reg : in_im;
        push_item.cls    = cls;
        push_item.offset = m - start_reg;
        push_item.recip  = recip_reg;
        push_item.last   = last;
    end

    // Row setup arithmetic
    always_comb
    begin
        afrac     = cfg.taper_fraction[FRAC_W-1] ? FRAC_W'(-cfg.taper_fraction)
                                                 : FRAC_W'(cfg.taper_fraction);
        frac_pos  = (cfg.taper_fraction > 16'sd0);
        frac_oor  = (cfg.taper_fraction < -16'sd2048) || (cfg.taper_fraction > 16'sd4096);
        ntap_prod = 54'(afrac) * 54'({kpos_reg, 1'b0});
        tap_x     = 15'(len_eff) * 15'd3;
        tap_prod  = 30'(tap_x) * 30'd26215;
        clip_x    = 16'(nyq) * 16'd17;
        clip_prod = 32'(clip_x) * 32'd52429;
        kpos20    = 42'(kpos_reg) * 42'd20;
        nyq17q    = {2'b0, clip_x, 24'b0};
        nyq_q     = {1'b0, nyq, 24'b0};
        kint      = kpos_reg[KPOS_W-1:24];
        kpos_sum  = 43'(kpos_reg) + {1'b0, ntap_reg, 24'b0};

        if (frac_pos)
        begin
            if (kpos_sum < 43'(nyq_q))
            begin
                ik1 = 19'(kint) + 19'(ntap_reg);
                nt  = 19'(ntap_reg);
            end
            else
            begin
                ik1 = 19'(nyq);
                nt  = 19'(tap_q_reg);
            end
        end
        else
        begin
            ik1 = (kpos_reg < nyq_q) ? 19'(kint) : 19'(nyq);
            nt  = 19'(ntap_reg);
        end
        ik2 = (nt > ik1) ? '0 : ik1 - nt;
        if (frac_oor)
        begin
            ik1 = 19'(nyq) - 19'd1;
            ik2 = hi_reg ? 19'(clip_reg) : 19'(kint);
        end
        if (ik2 > ik1)
            ik2 = ik1;

        trial = {rem_reg[BIN_W-1:0], (dcnt_reg == 5'(RECIP_W - 1))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bin_reg   <= '0;
            start_reg <= '0;
            cut_reg   <= '0;
            recip_reg <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser)
                        begin
                            bin_reg   <= '0;
                            state_reg <= ST_KPOS;
                        end
                        else
                        begin
                            bin_reg <= bin_next;
                        end
                    end
                end
                ST_KPOS:
                begin
                    state_reg <= ST_NTAP;
                end
                ST_NTAP:
                begin
                    state_reg <= ST_EDGE;
                end
                ST_EDGE:
                begin
                    cut_reg   <= ik1[BIN_W-1:0];
                    start_reg <= ik2[BIN_W-1:0];
                    dcnt_reg  <= 5'(RECIP_W - 1);
                    if (ik1 > ik2)
                        state_reg <= ST_DIV;
                    else
                    begin
                        recip_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        recip_reg <= {quo_reg[RECIP_W-2:0], (trial >= {1'b0, div_reg})};
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!full)
                    begin
                        bin_reg   <= bin_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser)
        begin
            hold_re_reg <= in_re;
            hold_im_reg <= in_im;
            hold_wn_reg <= in_wn;
        end
        if (state_reg == ST_KPOS)
            kpos_reg <= cfg.open_to_nyquist ? nyq_q
                                            : KPOS_W'(hold_wn_reg) * KPOS_W'(cfg.angle_sine);
        if (state_reg == ST_NTAP)
        begin
            ntap_reg  <= ntap_prod[53:36];
            tap_q_reg <= 18'(tap_prod[29:20]);
            clip_reg  <= clip_prod[31:20];
            hi_reg    <= (kpos20 > nyq17q);
        end
        if (state_reg == ST_EDGE)
        begin
            div_reg <= BIN_W'(ik1 - ik2);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            // restoring divide of 2^17 by the taper width, one quotient bit a cycle
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= trial - {1'b0, div_reg};
                quo_reg <= {quo_reg[RECIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[RECIP_W-2:0], 1'b0};
            end
        end
    end

endmodule

[sv/wdtf_back.sv]
module wdtf_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  wdtf_pkg::work_item_t              q_item,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wdtf_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import wdtf_pkg::*;

    localparam int PROD_W    = BIN_W + RECIP_W;
    localparam int IDX_SHIFT = 17 - TABLE_AW;

    logic                        adv;
    logic                        v1_reg, v2_reg, v3_reg;
    logic signed [SAMPLE_W-1:0]  re1_reg, im1_reg, re2_reg, im2_reg;
    logic signed [SAMPLE_W-1:0]  re3_reg, im3_reg;
    weight_class_t               cls1_reg;
    logic [PROD_W-1:0]           prod1_reg;
    logic                        last1_reg, last2_reg, last3_reg;
    logic [WEIGHT_W-1:0]         w2_reg, w_next;
    logic [PROD_W-IDX_SHIFT-1:0] idx_full;
    logic [TABLE_AW-1:0]         idx;

    function automatic logic signed [SAMPLE_W-1:0] scale_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [WEIGHT_W-1:0]        w
    );
        logic signed [SAMPLE_W+WEIGHT_W:0] p;
        p = s * $signed({1'b0, w});
        // bias negatives so the shift truncates toward zero
        if (p < 0)
            p = p + (SAMPLE_W+WEIGHT_W+1)'(65535);
        return p[SAMPLE_W+15:16];
    endfunction

    assign adv      = !v3_reg || m_tready;
    assign pop      = adv && q_valid;
    assign m_tvalid = v3_reg;
    assign m_tdata  = {im3_reg, re3_reg};
    assign m_tlast  = last3_reg;

    always_comb
    begin
        idx_full = prod1_reg[PROD_W-1:IDX_SHIFT];
        if (idx_full > (PROD_W-IDX_SHIFT)'(TABLE_DEPTH - 1))
            idx = TABLE_AW'(TABLE_DEPTH - 1);
        else
            idx = idx_full[TABLE_AW-1:0];
        case (cls1_reg)
            WCLS_ONE:   w_next = WEIGHT_ONE;
            WCLS_TAPER: w_next = COS_TABLE[idx];
            default:    w_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re1_reg   <= q_item.re;
            im1_reg   <= q_item.im;
            cls1_reg  <= q_item.cls;
            prod1_reg <= PROD_W'(q_item.offset) * PROD_W'(q_item.recip);
            last1_reg <= q_item.last;

            re2_reg   <= re1_reg;
            im2_reg   <= im1_reg;
            w2_reg    <= w_next;
            last2_reg <= last1_reg;

            re3_reg   <= scale_sample(re2_reg, w2_reg);
            im3_reg   <= scale_sample(im2_reg, w2_reg);
            last3_reg <= last2_reg;
        end
    end

endmodule

[sv/wavenumber_dip_taper_filter.sv]
// Path: a plain sample goes through the queue and the back pipeline (offset product,
//   weight lookup, scaling); a row-start sample first runs the front's edge setup
//   (KPOS, NTAP, EDGE), the reciprocal division (DIV, skipped for an empty taper) and EMIT.
// Throughput: one sample per cycle within a row while the queue has room; a row-start
//   beat keeps the input closed until the row setup and bit-serial divider in the front finish.
// Reset: asynchronous active low; clears config to defaults and all edges to zero.
module wavenumber_dip_taper_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [wdtf_pkg::TDATA_IN_W-1:0]        s_tdata,   // sample_re, sample_im, row_wavenumber
    input  logic                                   s_tuser,   // row_start
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [wdtf_pkg::TDATA_OUT_W-1:0]       m_tdata,   // filtered_re, filtered_im
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wdtf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [wdtf_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import wdtf_pkg::*;

    cfg_t       cfg_reg;
    logic       push, full, pop, q_valid;
    work_item_t push_item, q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length      <= LEN_W'(256);
            cfg_reg.angle_sine      <= SINE_W'(65536);
            cfg_reg.open_to_nyquist <= 1'b0;
            cfg_reg.taper_fraction  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_LENGTH:      cfg_reg.row_length      <= cfg_data[LEN_W-1:0];
                CFG_ANGLE_SINE:      cfg_reg.angle_sine      <= cfg_data[SINE_W-1:0];
                CFG_OPEN_TO_NYQUIST: cfg_reg.open_to_nyquist <= cfg_data[0];
                CFG_TAPER_FRACTION:  cfg_reg.taper_fraction  <= cfg_data[FRAC_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    wdtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    wdtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    wdtf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/wdtf_checker.sv]
`include "wavenumber_dip_taper_filter_defines.svh"

module wdtf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [wdtf_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input logic                                m_tlast
);
    logic [5:0] pending_reg;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // count samples in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 6'(in_beat) - 6'(out_beat);
    end

    `WDTF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat dropped or changed while stalled")
    `WDTF_ASSERT_NEXT(a_row_setup_stall, in_beat && s_tuser, !s_tready, "input not held during row setup")
    `WDTF_ASSERT_NOW(a_no_phantom, out_beat, pending_reg != 6'd0, "output beat without a pending input")

endmodule

bind wavenumber_dip_taper_filter wdtf_checker u_wdtf_checker (.*);
